// ===== rtl/brpu_pkg.sv =====
// Shared types, constants and helpers of the bitmap row pixel unpacker.
// Depends on nothing; imported by bitmap_row_pixel_unpacker_unit.
package brpu_pkg;

	localparam int MAX_WIDTH     = 1024;
	localparam int MAX_HEIGHT    = 1024;
	localparam int PALETTE_DEPTH = 256;
	localparam int MAX_STRIDE    = 4096;
	localparam int PAL_AW        = $clog2(PALETTE_DEPTH);

	localparam int GRAY16_STEP = 32 * 3 / 4;
	localparam int GRAY24_STEP = 256 * 3 / 4;

	localparam logic [7:0] NIB_TOP = 8'hf0;
	localparam logic [7:0] NIB_MID = 8'ha0;

	localparam logic OP_PALETTE = 1'b0;
	localparam logic OP_DATA    = 1'b1;

	localparam logic MODE_GRAY  = 1'b0;
	localparam logic MODE_COLOR = 1'b1;

	typedef enum logic [2:0] {
		DEPTH_1  = 3'd0,
		DEPTH_2  = 3'd1,
		DEPTH_4  = 3'd2,
		DEPTH_8  = 3'd3,
		DEPTH_16 = 3'd4,
		DEPTH_24 = 3'd5
	} depth_t;

	typedef enum logic [2:0] {
		REG_DEPTH     = 3'd0,
		REG_MODE      = 3'd1,
		REG_PIXELS    = 3'd2,
		REG_STRIDE    = 3'd3,
		REG_ROWS_KEPT = 3'd4,
		REG_ROWS_SKIP = 3'd5
	} cfg_reg_t;

	function automatic depth_t eff_depth(input logic [2:0] code);
		if (code > 3'd5) begin
			return DEPTH_24;
		end
		return depth_t'(code);
	endfunction

	function automatic logic [1:0] gray_of_entry(input logic [23:0] entry);
		logic [7:0] nib;
		nib = {entry[23:20], 4'h0};
		if (nib == 8'h00) begin
			return 2'd0;
		end
		if (nib == NIB_TOP) begin
			return 2'd3;
		end
		if (nib < NIB_MID) begin
			return 2'd1;
		end
		return 2'd2;
	endfunction

	function automatic logic [1:0] gray_of_sum16(input logic [6:0] sum);
		if (sum >= 7'(3 * GRAY16_STEP)) begin
			return 2'd3;
		end
		if (sum >= 7'(2 * GRAY16_STEP)) begin
			return 2'd2;
		end
		if (sum >= 7'(GRAY16_STEP)) begin
			return 2'd1;
		end
		return 2'd0;
	endfunction

	function automatic logic [1:0] gray_of_sum24(input logic [9:0] sum);
		if (sum >= 10'(3 * GRAY24_STEP)) begin
			return 2'd3;
		end
		if (sum >= 10'(2 * GRAY24_STEP)) begin
			return 2'd2;
		end
		if (sum >= 10'(GRAY24_STEP)) begin
			return 2'd1;
		end
		return 2'd0;
	endfunction

endpackage

// ===== rtl/bitmap_row_pixel_unpacker_unit.sv =====
// Bitmap row pixel unpacker: palette store, row/column tracking, pixel emitter.
// Depends on brpu_pkg.
// Path: an accepted data byte is registered in s1, then in s2, which drives the output.
// Throughput: one byte per cycle at 8, 16 and 24 bits per pixel while out_ready
// holds; a byte at 1, 2 or 4 bits per pixel holds the input until its last pixel
// (up to 8) moves to s2, since the output register takes at most one pixel per cycle.
// Reset: registers to their defaults, counters cleared; palette contents are
// undefined until written, with no clearing pass.
module bitmap_row_pixel_unpacker_unit import brpu_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        operation,
	input  logic [7:0]  data_byte,
	input  logic [7:0]  palette_index,
	input  logic [7:0]  palette_red,
	input  logic [7:0]  palette_green,
	input  logic [7:0]  palette_blue,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [23:0] pixel_value,
	output logic [9:0]  column,
	output logic [9:0]  row,
	output logic        row_end,
	output logic        last_of_burst
);

	logic [2:0]  depth_q;
	logic        mode_q;
	logic [10:0] ppr_q;
	logic [12:0] bpr_q;
	logic [10:0] kept_q;
	logic [15:0] skip_q;

	logic [11:0] bpos_q;
	logic [10:0] pcol_q;
	logic [16:0] rcnt_q;
	logic [7:0]  b0_q;
	logic [7:0]  b1_q;
	logic [1:0]  held_q;

	logic [23:0] pal_mem [PALETTE_DEPTH];

	logic        s1_valid_q;
	logic [7:0]  shift_s1;
	logic [3:0]  rem_s1;
	logic [9:0]  col_s1;
	logic [9:0]  row_s1;
	logic        sub_s1;
	logic [23:0] val_s1;

	logic        s2_valid_q;
	logic [23:0] pal_s2;
	logic        sub_s2;
	logic        oob_s2;
	logic [23:0] val_s2;
	logic [9:0]  col_s2;
	logic [9:0]  row_s2;
	logic        end_s2;
	logic        last_s2;

	logic [10:0] width_c;
	logic [10:0] kept_c;
	logic [12:0] stride_c;
	logic [16:0] limit_c;
	logic        done_c;
	logic        decode_c;
	logic [16:0] rel_c;
	logic [10:0] row_c;
	depth_t      code_c;
	logic        sub_c;
	logic [3:0]  per_c;
	logic        col_ok_c;
	logic [10:0] avail_c;
	logic [3:0]  n_sub_c;
	logic [1:0]  need_c;
	logic        complete_c;
	logic [3:0]  n_c;
	logic        row_wrap_c;
	logic [15:0] z_c;
	logic [6:0]  sum16_c;
	logic [9:0]  sum24_c;
	logic [23:0] val_c;

	logic        in_acc;
	logic        data_acc;
	logic        pal_we;
	logic        s1_load;
	logic        s2_load;
	logic        s1_last;
	logic [7:0]  idx_s1;
	logic [7:0]  shift_next;
	logic        oob_s1;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q <= 3'(DEPTH_24);
			mode_q  <= MODE_COLOR;
			ppr_q   <= 11'd1024;
			bpr_q   <= 13'd3072;
			kept_q  <= 11'd1024;
			skip_q  <= 16'd0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_DEPTH:     depth_q <= cfg_data[2:0];
				REG_MODE:      mode_q  <= cfg_data[0];
				REG_PIXELS:    ppr_q   <= cfg_data[10:0];
				REG_STRIDE:    bpr_q   <= cfg_data[12:0];
				REG_ROWS_KEPT: kept_q  <= cfg_data[10:0];
				REG_ROWS_SKIP: skip_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		width_c  = (ppr_q > 11'(MAX_WIDTH)) ? 11'(MAX_WIDTH) : ppr_q;
		kept_c   = (kept_q > 11'(MAX_HEIGHT)) ? 11'(MAX_HEIGHT) : kept_q;
		stride_c = (bpr_q == 13'd0) ? 13'd1 :
		           ((bpr_q > 13'(MAX_STRIDE)) ? 13'(MAX_STRIDE) : bpr_q);
		limit_c  = {1'b0, skip_q} + {6'b0, kept_c};
		done_c   = rcnt_q >= limit_c;
		decode_c = rcnt_q >= {1'b0, skip_q};
		rel_c    = rcnt_q - {1'b0, skip_q};
		row_c    = kept_c - 11'd1 - rel_c[10:0];
		code_c   = eff_depth(depth_q);
		sub_c    = (code_c == DEPTH_1) || (code_c == DEPTH_2) ||
		           (code_c == DEPTH_4) || (code_c == DEPTH_8);
		case (code_c)
			DEPTH_1: per_c = 4'd8;
			DEPTH_2: per_c = 4'd4;
			DEPTH_4: per_c = 4'd2;
			default: per_c = 4'd1;
		endcase
		col_ok_c = pcol_q < width_c;
		avail_c  = width_c - pcol_q;
		if (!col_ok_c) begin
			n_sub_c = 4'd0;
		end else if (avail_c < {7'b0, per_c}) begin
			n_sub_c = avail_c[3:0];
		end else begin
			n_sub_c = per_c;
		end
		need_c     = (code_c == DEPTH_16) ? 2'd2 : 2'd3;
		complete_c = ({1'b0, held_q} + 3'd1) >= {1'b0, need_c};
		n_c        = sub_c ? n_sub_c : {3'b0, complete_c && col_ok_c};
		row_wrap_c = ({1'b0, bpos_q} + 13'd1) >= stride_c;

		z_c     = {data_byte, b0_q};
		sum16_c = {2'b0, z_c[15:11]} + {2'b0, z_c[10:6]} + {2'b0, z_c[4:0]};
		sum24_c = {2'b0, b0_q} + {2'b0, b1_q} + {2'b0, data_byte};
		if (code_c == DEPTH_16) begin
			val_c = (mode_q == MODE_COLOR) ?
			        {z_c[4:0], 3'b0, z_c[9:5], 3'b0, z_c[14:10], 3'b0} :
			        {22'b0, gray_of_sum16(sum16_c)};
		end else begin
			val_c = (mode_q == MODE_COLOR) ? {b0_q, b1_q, data_byte} :
			        {22'b0, gray_of_sum24(sum24_c)};
		end
	end

	always_comb begin
		case (code_c)
			DEPTH_1: begin
				idx_s1     = {7'b0, shift_s1[7]};
				shift_next = {shift_s1[6:0], 1'b0};
			end
			DEPTH_2: begin
				idx_s1     = {6'b0, shift_s1[7:6]};
				shift_next = {shift_s1[5:0], 2'b0};
			end
			DEPTH_4: begin
				idx_s1     = {4'b0, shift_s1[7:4]};
				shift_next = {shift_s1[3:0], 4'b0};
			end
			default: begin
				idx_s1     = shift_s1;
				shift_next = shift_s1;
			end
		endcase
		oob_s1 = int'(idx_s1) >= PALETTE_DEPTH;
	end

	assign in_acc   = in_valid && in_ready;
	assign data_acc = in_acc && (operation == OP_DATA) && !done_c;
	assign pal_we   = in_acc && (operation == OP_PALETTE) &&
	                  (int'(palette_index) < PALETTE_DEPTH);
	assign s1_load  = data_acc && decode_c && (n_c != 4'd0);
	assign s2_load  = s1_valid_q && (!s2_valid_q || out_ready);
	assign s1_last  = rem_s1 == 4'd1;
	assign in_ready = !s1_valid_q || (s2_load && s1_last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bpos_q <= '0;
			pcol_q <= '0;
			rcnt_q <= '0;
			b0_q   <= '0;
			b1_q   <= '0;
			held_q <= '0;
		end else if (data_acc) begin
			if (row_wrap_c) begin
				bpos_q <= '0;
				pcol_q <= '0;
				held_q <= '0;
				b0_q   <= '0;
				b1_q   <= '0;
				rcnt_q <= rcnt_q + 17'd1;
			end else begin
				bpos_q <= bpos_q + 12'd1;
				if (decode_c) begin
					if (sub_c) begin
						pcol_q <= pcol_q + {7'b0, n_sub_c};
					end else if (complete_c) begin
						held_q <= '0;
						b0_q   <= '0;
						b1_q   <= '0;
						pcol_q <= pcol_q + {10'b0, col_ok_c};
					end else begin
						held_q <= held_q + 2'd1;
						if (held_q == 2'd0) begin
							b0_q <= data_byte;
						end else if (held_q == 2'd1) begin
							b1_q <= data_byte;
						end
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			s2_valid_q <= 1'b0;
		end else begin
			if (s1_load) begin
				s1_valid_q <= 1'b1;
			end else if (s2_load && s1_last) begin
				s1_valid_q <= 1'b0;
			end
			if (s2_load) begin
				s2_valid_q <= 1'b1;
			end else if (out_ready) begin
				s2_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_load) begin
			shift_s1 <= data_byte;
			rem_s1   <= n_c;
			col_s1   <= pcol_q[9:0];
			row_s1   <= row_c[9:0];
			sub_s1   <= sub_c;
			val_s1   <= val_c;
		end else if (s2_load && !s1_last) begin
			shift_s1 <= shift_next;
			rem_s1   <= rem_s1 - 4'd1;
			col_s1   <= col_s1 + 10'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (pal_we) begin
			pal_mem[palette_index[PAL_AW-1:0]] <= {palette_blue, palette_green, palette_red};
		end
		if (s2_load) begin
			pal_s2 <= pal_mem[idx_s1[PAL_AW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (s2_load) begin
			sub_s2  <= sub_s1;
			oob_s2  <= oob_s1;
			val_s2  <= val_s1;
			col_s2  <= col_s1;
			row_s2  <= row_s1;
			end_s2  <= ({1'b0, col_s1} + 11'd1) == width_c;
			last_s2 <= s1_last;
		end
	end

	always_comb begin
		if (!sub_s2) begin
			pixel_value = val_s2;
		end else if (oob_s2) begin
			pixel_value = '0;
		end else if (mode_q == MODE_COLOR) begin
			pixel_value = pal_s2;
		end else begin
			pixel_value = {22'b0, gray_of_entry(pal_s2)};
		end
	end

	assign out_valid     = s2_valid_q;
	assign column        = col_s2;
	assign row           = row_s2;
	assign row_end       = end_s2;
	assign last_of_burst = last_s2;

	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q |-> (rem_s1 != 4'd0) && (rem_s1 <= 4'd8))
		else $error("pixel count of held byte out of range");

	a_busy_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q && !s1_last) |-> !in_ready)
		else $error("input taken while a burst is still pending");

	a_column_in_width: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ({1'b0, column} < width_c))
		else $error("pixel column beyond row width");

	a_gray_range: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (mode_q == MODE_GRAY)) |-> (pixel_value[23:2] == 22'd0))
		else $error("gray pixel wider than two bits");

	a_column_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pcol_q <= 11'(MAX_WIDTH))
		else $error("column counter past maximum width");

	a_held_bound: assert property (@(posedge clk) disable iff (!arst_n)
		held_q != 2'd3)
		else $error("too many bytes held for one pixel");

endmodule
